// ----- rtl/core/frustum_aabb_cull_macros.svh -----
// ----------------------------------------------------------------------------
// frustum_aabb_cull assertion macros
// shared property forms for the culling block, clock and reset by port name
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_AABB_CULL_MACROS_SVH
`define FRUSTUM_AABB_CULL_MACROS_SVH

// implication in the same cycle, off during reset
`define FAC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication into the next cycle, live during reset
`define FAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fac_pkg.sv -----
// ----------------------------------------------------------------------------
// fac_pkg
// types, widths and helpers shared by the frustum culling block
// ----------------------------------------------------------------------------
package fac_pkg;

   localparam int COORD_BITS  = 24;
   localparam int ELEM_BITS   = 32;
   localparam int COEF_BITS   = ELEM_BITS + 1;
   localparam int PROD_BITS   = COEF_BITS + COORD_BITS;
   localparam int ACC_BITS    = PROD_BITS + 3;
   localparam int REG_BITS    = 2 * ELEM_BITS;
   localparam int NUM_REGS    = 8;
   localparam int IDX_BITS    = 4;
   localparam int NUM_PLANES  = 6;
   localparam int PLANE_BITS  = 3;
   localparam int BOX_BITS    = 6 * COORD_BITS;
   localparam int RSP_BITS    = 8;

   localparam logic [PLANE_BITS-1:0] NO_REJECT = PLANE_BITS'(NUM_PLANES);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type max_z;
      coord_type max_y;
      coord_type max_x;
      coord_type min_z;
      coord_type min_y;
      coord_type min_x;
   } box_type;

   typedef struct packed {
      coef_type cw;
      coef_type cz;
      coef_type cy;
      coef_type cx;
   } plane_type;

   typedef struct packed {
      box_type                box;
      logic [PLANE_BITS-1:0]  reject;
   } item_type;

   // row3 plus or minus another row, one column
   function automatic coef_type plane_coef(logic [ELEM_BITS-1:0] a,
                                           logic [ELEM_BITS-1:0] b,
                                           logic minus);
      coef_type ea;
      coef_type eb;
      ea = COEF_BITS'($signed(a));
      eb = COEF_BITS'($signed(b));
      return minus ? ea - eb : ea + eb;
   endfunction

   function automatic logic coef_pos(coef_type c);
      return !c[COEF_BITS-1] && (c != '0);
   endfunction

endpackage

// ----- rtl/core/fac_csr.sv -----
// ----------------------------------------------------------------------------
// fac_csr
// matrix registers and the six plane coefficient sets formed from them
// ----------------------------------------------------------------------------
module fac_csr import fac_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [IDX_BITS-1:0]  csr_index,
   input  logic [REG_BITS-1:0]  csr_wdata,
   output plane_type            planes [NUM_PLANES]
);

   logic [REG_BITS-1:0] mat_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (csr_wen && (csr_index < IDX_BITS'(NUM_REGS))) begin
         mat_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   // planes: row3 +/- row0, row1, row2 in order left, right, bottom, top, near, far
   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      localparam int ROW = p / 2;
      localparam logic MINUS = (p % 2) == 1;
      assign planes[p].cx = plane_coef(mat_ff[6][ELEM_BITS-1:0],
                                       mat_ff[2*ROW][ELEM_BITS-1:0], MINUS);
      assign planes[p].cy = plane_coef(mat_ff[6][REG_BITS-1:ELEM_BITS],
                                       mat_ff[2*ROW][REG_BITS-1:ELEM_BITS], MINUS);
      assign planes[p].cz = plane_coef(mat_ff[7][ELEM_BITS-1:0],
                                       mat_ff[2*ROW+1][ELEM_BITS-1:0], MINUS);
      assign planes[p].cw = plane_coef(mat_ff[7][REG_BITS-1:ELEM_BITS],
                                       mat_ff[2*ROW+1][REG_BITS-1:ELEM_BITS], MINUS);
   end

endmodule

// ----- rtl/core/fac_cell.sv -----
// ----------------------------------------------------------------------------
// fac_cell
// one plane test in three stages: p-vertex select, multiply, sum and sign
// ----------------------------------------------------------------------------
module fac_cell import fac_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  plane_type              plane,
   input  logic [PLANE_BITS-1:0]  plane_idx,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  item_type               in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output item_type               out_item
);

   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic       s1_ready, s2_ready, s3_ready;
   item_type   s1_item_ff, s2_item_ff, s3_item_ff;
   item_type   s3_item_in;
   plane_type  s1_coef_ff;
   coord_type  s1_vtx_ff [3];
   coord_type  s1_vtx_in [3];
   prod_type   s2_prod_ff [3];
   prod_type   s2_prod_in [3];
   coef_type   s2_w_ff;
   logic signed [ACC_BITS-1:0] acc;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // p-vertex: max where the coefficient is strictly positive
   always_comb begin
      s1_vtx_in[0] = coef_pos(plane.cx) ? in_item.box.max_x : in_item.box.min_x;
      s1_vtx_in[1] = coef_pos(plane.cy) ? in_item.box.max_y : in_item.box.min_y;
      s1_vtx_in[2] = coef_pos(plane.cz) ? in_item.box.max_z : in_item.box.min_z;
   end

   always_comb begin
      s2_prod_in[0] = PROD_BITS'(s1_coef_ff.cx) * PROD_BITS'(s1_vtx_ff[0]);
      s2_prod_in[1] = PROD_BITS'(s1_coef_ff.cy) * PROD_BITS'(s1_vtx_ff[1]);
      s2_prod_in[2] = PROD_BITS'(s1_coef_ff.cz) * PROD_BITS'(s1_vtx_ff[2]);
   end

   always_comb begin
      acc = ACC_BITS'(s2_prod_ff[0]) + ACC_BITS'(s2_prod_ff[1])
          + ACC_BITS'(s2_prod_ff[2]) + ACC_BITS'(s2_w_ff);
      s3_item_in = s2_item_ff;
      if ((s2_item_ff.reject == NO_REJECT) && acc[ACC_BITS-1]) begin
         s3_item_in.reject = plane_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_item_ff <= in_item;
         s1_coef_ff <= plane;
         s1_vtx_ff  <= s1_vtx_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_prod_ff <= s2_prod_in;
         s2_w_ff    <= s1_coef_ff.cw;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

// ----- rtl/core/frustum_aabb_cull.sv -----
// ----------------------------------------------------------------------------
// frustum_aabb_cull
// view-frustum test of axis-aligned boxes against a q16.16 matrix
//
//   channel  dir  width  contents
//   req      in   144    box min x,y,z then max x,y,z
//   rsp      out  8      visible, reject plane
//   csr      in   64     matrix rows, index 0 to 7
//
// one item per cycle while rsp_tready holds; six plane cells of three stages
// each stage holds its item until the next one frees, so bubbles close up
// synchronous reset clears the matrix and every stage valid bit
// ----------------------------------------------------------------------------
module frustum_aabb_cull import fac_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BOX_BITS-1:0]  req_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_BITS-1:0]  rsp_tdata,   // visible, reject_plane[2:0], zero pad
   input  logic                 csr_wen,
   input  logic [IDX_BITS-1:0]  csr_index,
   input  logic [REG_BITS-1:0]  csr_wdata
);

`include "frustum_aabb_cull_macros.svh"

   plane_type  planes [NUM_PLANES];
   logic       link_valid [NUM_PLANES+1];
   logic       link_ready [NUM_PLANES+1];
   item_type   link_item  [NUM_PLANES+1];
   item_type   last_item;

   fac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .planes    (planes)
   );

   assign link_valid[0]       = req_tvalid;
   assign req_tready          = link_ready[0];
   assign link_item[0].box    = box_type'(req_tdata);
   assign link_item[0].reject = NO_REJECT;

   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      fac_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane     (planes[g]),
         .plane_idx (PLANE_BITS'(g)),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_item   (link_item[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_item  (link_item[g+1])
      );
   end

   assign last_item               = link_item[NUM_PLANES];
   assign rsp_tvalid              = link_valid[NUM_PLANES];
   assign link_ready[NUM_PLANES]  = rsp_tready;
   assign rsp_tdata = {(RSP_BITS - PLANE_BITS - 1)'(0), last_item.reject,
                       last_item.reject == NO_REJECT};

   `FAC_ASSERT_IMPL(a_reject_range, rsp_tvalid, rsp_tdata[3:1] <= NO_REJECT, "reject plane out of range")
   `FAC_ASSERT_IMPL(a_empty_takes, !rsp_tvalid, req_tready, "empty output yet input blocked")
   `FAC_ASSERT_NEXT(a_reset_empty, reset, !rsp_tvalid, "output valid after reset")

endmodule
